>>> rtl/core/mscg_pkg.sv
// Shared types and constants for the multi-stop colour gradient unit.
// No dependencies.
`timescale 1ns / 1ps

package mscg_pkg;

    localparam int MAX_POINTS_DEF = 6;
    localparam int COUNT_W        = 3;
    localparam int INDEX_W        = 3;
    localparam int POINT_W        = 56;
    localparam int POS_W          = 32;
    localparam int COLOR_W        = 24;
    localparam int RATIO_W        = 16;

    localparam logic [INDEX_W-1:0] REG_POINT_COUNT = 3'd0;

    // Payload that rides alongside the divider
    typedef struct packed {
        logic               matched;
        logic [COLOR_W-1:0] ca;
        logic [COLOR_W-1:0] cb;
    } side_t;

endpackage

>>> rtl/core/mscg_seg_select.sv
// Segment search: bound compares, then first-match selection and span.
// Depends on mscg_pkg.
`timescale 1ns / 1ps

module mscg_seg_select #(
    parameter int MAX_POINTS = mscg_pkg::MAX_POINTS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  logic                                     in_valid,
    input  logic signed [mscg_pkg::POS_W-1:0]        sample,
    input  logic [mscg_pkg::COUNT_W-1:0]             point_count,
    input  logic [MAX_POINTS-1:0][mscg_pkg::POINT_W-1:0] points,
    output logic                                     out_valid,
    output logic [mscg_pkg::POS_W-1:0]               offset,
    output logic [mscg_pkg::POS_W-1:0]               span,
    output mscg_pkg::side_t                          side
);
    import mscg_pkg::*;

    localparam int SEGS = MAX_POINTS - 1;

    logic                    v1_reg;
    logic signed [POS_W-1:0] sample_reg;
    logic [SEGS-1:0]         hit_reg;
    logic [SEGS-1:0]         hit_next;
    logic [COUNT_W-1:0]      n_sat;

    logic                    v2_reg;
    logic [POS_W-1:0]        dist_reg;
    logic [POS_W-1:0]        span_reg;
    side_t                   side_reg;

    logic signed [POS_W-1:0] p1_sel;
    logic signed [POS_W-1:0] p2_sel;
    logic [COLOR_W-1:0]      ca_sel;
    logic [COLOR_W-1:0]      cb_sel;
    logic                    found;
    logic signed [POS_W:0]   dist_wide;
    logic signed [POS_W:0]   span_wide;

    always_comb
    begin
        n_sat = (point_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : point_count;
        for (int i = 0; i < SEGS; i++)
        begin
            hit_next[i] = (n_sat > COUNT_W'(i + 1))
                && (sample >= $signed(points[i][POINT_W-1:COLOR_W]))
                && (sample <= $signed(points[i+1][POINT_W-1:COLOR_W]));
        end
    end

    // Walk from the top down so the lowest hit wins
    always_comb
    begin
        p1_sel = '0;
        p2_sel = '0;
        ca_sel = '0;
        cb_sel = '0;
        found  = 1'b0;
        for (int i = SEGS - 1; i >= 0; i--)
        begin
            if (hit_reg[i])
            begin
                p1_sel = $signed(points[i][POINT_W-1:COLOR_W]);
                p2_sel = $signed(points[i+1][POINT_W-1:COLOR_W]);
                ca_sel = points[i][COLOR_W-1:0];
                cb_sel = points[i+1][COLOR_W-1:0];
                found  = 1'b1;
            end
        end
        dist_wide = {sample_reg[POS_W-1], sample_reg} - {p1_sel[POS_W-1], p1_sel};
        span_wide = {p2_sel[POS_W-1], p2_sel} - {p1_sel[POS_W-1], p1_sel};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg       <= sample;
            hit_reg          <= hit_next;
            dist_reg         <= found ? dist_wide[POS_W-1:0] : '0;
            span_reg         <= found ? span_wide[POS_W-1:0] : '0;
            side_reg.matched <= found;
            side_reg.ca      <= found ? ca_sel : '0;
            side_reg.cb      <= found ? cb_sel : '0;
        end
    end

    assign out_valid = v2_reg;
    assign offset    = dist_reg;
    assign span      = span_reg;
    assign side      = side_reg;

endmodule

>>> rtl/core/mscg_divider.sv
// Pipelined restoring divider: ratio = offset * 65280 / span, one bit a stage.
// Depends on mscg_pkg.
`timescale 1ns / 1ps

module mscg_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [mscg_pkg::POS_W-1:0]    offset,
    input  logic [mscg_pkg::POS_W-1:0]    span,
    input  mscg_pkg::side_t               side_in,
    output logic                          out_valid,
    output logic [mscg_pkg::RATIO_W-1:0]  ratio,
    output mscg_pkg::side_t               side_out
);
    import mscg_pkg::*;

    localparam int NUM_W = POS_W + RATIO_W;

    logic               v_reg    [RATIO_W+1];
    logic [POS_W-1:0]   rem_reg  [RATIO_W+1];
    logic [RATIO_W-1:0] low_reg  [RATIO_W+1];
    logic [RATIO_W-1:0] q_reg    [RATIO_W+1];
    logic [POS_W-1:0]   span_reg [RATIO_W+1];
    side_t              side_reg [RATIO_W+1];

    logic [NUM_W-1:0]   num;

    // offset * 65280 = offset * 2^16 - offset * 2^8
    assign num = {offset, {RATIO_W{1'b0}}} - {8'd0, offset, 8'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= num[NUM_W-1:RATIO_W];
            low_reg[0]  <= num[RATIO_W-1:0];
            q_reg[0]    <= '0;
            span_reg[0] <= span;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < RATIO_W; k++)
    begin : g_stage
        logic [POS_W:0] shifted;
        logic [POS_W:0] diff;
        logic           take;

        always_comb
        begin
            shifted = {rem_reg[k], low_reg[k][RATIO_W-1]};
            diff    = shifted - {1'b0, span_reg[k]};
            take    = shifted >= {1'b0, span_reg[k]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= take ? diff[POS_W-1:0] : shifted[POS_W-1:0];
                low_reg[k+1]  <= {low_reg[k][RATIO_W-2:0], 1'b0};
                q_reg[k+1]    <= {q_reg[k][RATIO_W-2:0], take};
                span_reg[k+1] <= span_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // Equal positions give ratio zero
    assign out_valid = v_reg[RATIO_W];
    assign ratio     = (span_reg[RATIO_W] == '0) ? '0 : q_reg[RATIO_W];
    assign side_out  = side_reg[RATIO_W];

endmodule

>>> rtl/core/mscg_blend.sv
// Channel blend: weighted sum, then divide by 65280 and hold the output register.
// Depends on mscg_pkg.
`timescale 1ns / 1ps

module mscg_blend (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [mscg_pkg::RATIO_W-1:0]  ratio,
    input  mscg_pkg::side_t               side,
    output logic                          out_valid,
    output logic [mscg_pkg::COLOR_W-1:0]  color,
    output logic                          matched
);
    import mscg_pkg::*;

    localparam int CH = 3;

    logic               va_reg;
    logic [23:0]        num_reg [CH];
    logic               match_a_reg;
    logic               vb_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               match_b_reg;

    logic [23:0]        num_next [CH];
    logic [7:0]         chan     [CH];

    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            logic [7:0]         a;
            logic [7:0]         b;
            logic signed [8:0]  delta;
            logic signed [25:0] prod;
            logic signed [26:0] total;
            a        = side.ca[8*c +: 8];
            b        = side.cb[8*c +: 8];
            delta    = $signed({1'b0, b}) - $signed({1'b0, a});
            prod     = $signed({1'b0, ratio}) * delta;
            total    = $signed({3'd0, a, 16'd0}) - $signed({11'd0, a, 8'd0})
                     + {prod[25], prod};
            // Result always sits between the two stop values, so it is positive
            num_next[c] = total[23:0];
        end
    end

    // x / 255 for x below 65535 as (x + 1 + x/256) / 256
    always_comb
    begin
        for (int c = 0; c < CH; c++)
        begin
            logic [16:0] x_sum;
            x_sum   = {1'b0, num_reg[c][23:8]} + 17'd1 + {9'd0, num_reg[c][23:16]};
            chan[c] = x_sum[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < CH; c++)
            begin
                num_reg[c] <= num_next[c];
            end
            match_a_reg <= side.matched;
            color_reg   <= {chan[2], chan[1], chan[0]};
            match_b_reg <= match_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign color     = color_reg;
    assign matched   = match_b_reg;

endmodule

>>> rtl/core/multi_stop_color_gradient_unit.sv
// Multi-stop colour gradient: signed Q16.16 sample to RGB through up to MAX_POINTS stops.
// Pipeline stages: 2 segment search, 17 divider (operand load, then one quotient bit
// a stage), 2 blend.
// Throughput one item per cycle; the whole pipeline holds while the output item waits.
// Reset (rst_n, asynchronous) clears valid bits, stop count and stop registers.
// Depends on mscg_pkg, mscg_seg_select, mscg_divider, mscg_blend.
`timescale 1ns / 1ps

module multi_stop_color_gradient_unit #(
    parameter int MAX_POINTS = mscg_pkg::MAX_POINTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mscg_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [mscg_pkg::POINT_W-1:0]   cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [31:0]                    s_axis_tdata,   // [31:0] sample_value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,   // [23:0] color
    output logic                           m_axis_tuser    // [0] matched
);
    import mscg_pkg::*;

    logic [COUNT_W-1:0]                count_reg;
    logic [MAX_POINTS-1:0][POINT_W-1:0] point_reg;

    logic               en;
    logic               seg_valid;
    logic [POS_W-1:0]   seg_dist;
    logic [POS_W-1:0]   seg_span;
    side_t              seg_side;
    logic               div_valid;
    logic [RATIO_W-1:0] div_ratio;
    side_t              div_side;
    logic               out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            point_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_POINT_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                if (cfg_index == INDEX_W'(i + 1))
                begin
                    point_reg[i] <= cfg_data;
                end
            end
        end
    end

    // Advance everything unless the output item is stalled
    assign en            = !out_valid || m_axis_tready;
    assign s_axis_tready = en;

    mscg_seg_select #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seg (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_axis_tvalid),
        .sample      ($signed(s_axis_tdata)),
        .point_count (count_reg),
        .points      (point_reg),
        .out_valid   (seg_valid),
        .offset      (seg_dist),
        .span        (seg_span),
        .side        (seg_side)
    );

    mscg_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (seg_valid),
        .offset    (seg_dist),
        .span      (seg_span),
        .side_in   (seg_side),
        .out_valid (div_valid),
        .ratio     (div_ratio),
        .side_out  (div_side)
    );

    mscg_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .ratio     (div_ratio),
        .side      (div_side),
        .out_valid (out_valid),
        .color     (m_axis_tdata),
        .matched   (m_axis_tuser)
    );

    assign m_axis_tvalid = out_valid;

endmodule

>>> rtl/core/mscg_checker.sv
// Port-level checks for the colour gradient unit, bound to the top level.
// Depends on multi_stop_color_gradient_unit.
`timescale 1ns / 1ps

module mscg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // Unmatched items carry black
    a_unmatched_black: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 24'd0))
        else $error("unmatched item with non-zero colour");

    // Input is taken exactly when the output is free to move
    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready disagrees with output state");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output item changed");

endmodule

bind multi_stop_color_gradient_unit mscg_checker u_mscg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
